/* hw/rtl/orthonormal_frame_from_three_points_top_assert.svh */
// assertion macros shared by the frame block
`ifndef ORTHONORMAL_FRAME_FROM_THREE_POINTS_TOP_ASSERT_SVH
`define ORTHONORMAL_FRAME_FROM_THREE_POINTS_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked on clk, off during reset
`define OFR_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ofr assertion failed");
// next-cycle implication, checked on clk, off during reset
`define OFR_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ofr assertion failed");
`else
`define OFR_ASSERT_IMP(lbl, a, c)
`define OFR_ASSERT_NXT(lbl, a, c)
`endif
`endif

/* hw/rtl/ofr_pkg.sv */
package ofr_pkg;

  // the largest magnitude after block scaling sits in [2^29, 2^30)
  localparam int SCALE_W = 30;

  // block scaled vector: nonzero flag, signs and magnitudes
  typedef struct packed {
    logic                     nz;
    logic [2:0]               neg;
    logic [2:0][SCALE_W-1:0]  mag;
  } svec_t;

endpackage

/* hw/rtl/orthonormal_frame_from_three_points_top.sv */
// Orthonormal local frame from a center point C, a side point B and a
// reference point N. The y axis is N - C normalized, the x axis is B - C
// with its part along y removed and normalized, the z axis is x cross y.
// Input channel in_*: one word holds the nine coordinates, output channel
// out_*: one word holds the nine axis components, rows x, y, z; out_tuser
// flags a degenerate frame, whose nine components are then zero.
// Throughput: one word per cycle on both channels while the receiver takes
// each word; a stall that fills the skid register holds the input. The path
// from acceptance to out_tvalid runs through three normalization units, each
// of which runs a 31-stage square root and an AXIS_FRAC_BITS + 1 stage divider
// one bit per stage, plus the dot product, projection and cross product
// stages between them.
// Reset (synchronous, rst_n low) empties the pipeline and the output
// register; nothing else needs clearing.
// When the receiver stalls, a finished word waits in the output register and
// one more lands in a skid register; in_tready drops only while the skid
// register is full, and the whole pipeline holds without losing a word.
module orthonormal_frame_from_three_points_top #(
  parameter int COORD_WIDTH    = 20,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // center_x, center_y, center_z, side_x, side_y, side_z, ref_x, ref_y,
  // ref_z, zero fill
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z, zaxis_x,
  // zaxis_y, zaxis_z
  output logic [143:0]                           out_tdata,
  // degenerate
  output logic [0:0]                             out_tuser
);

  `include "orthonormal_frame_from_three_points_top_assert.svh"

  localparam int CW    = COORD_WIDTH;
  localparam int DW_I  = COORD_WIDTH + 1;
  localparam int AW    = AXIS_FRAC_BITS + 2;
  localparam int VS_W  = ofr_pkg::SCALE_W + 1;
  localparam int PRW   = AXIS_FRAC_BITS + 33;
  localparam int DW    = AXIS_FRAC_BITS + 35;
  localparam int P_W   = 33;
  localparam int W_W   = 34;
  localparam int CPW   = 2 * AW;
  localparam int ZW    = CPW + 1;
  localparam int SV_W  = $bits(ofr_pkg::svec_t);
  localparam int YS_W  = 1 + 3 * AW;
  localparam int ZS_W  = 1 + 6 * AW;
  localparam int AXO_W = 16;
  localparam int OD_W  = 9 * AXO_W;
  localparam logic [DW-1:0] HALF = DW'(1) << (AXIS_FRAC_BITS - 1);

  logic en;
  logic skid_full_r;

  assign en        = !skid_full_r;
  assign in_tready = en;

  // difference vectors B - C and N - C
  logic [2:0][DW_I-1:0] dif_v, dif_y;
  logic                 d_v_r;
  logic [2:0][DW_I-1:0] d_v_vec_r, d_y_vec_r;

  for (genvar i = 0; i < 3; i++) begin : g_dif
    assign dif_v[i] = DW_I'($signed(in_tdata[(i+3)*CW +: CW]))
                    - DW_I'($signed(in_tdata[i*CW +: CW]));
    assign dif_y[i] = DW_I'($signed(in_tdata[(i+6)*CW +: CW]))
                    - DW_I'($signed(in_tdata[i*CW +: CW]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_v_vec_r <= dif_v;
      d_y_vec_r <= dif_y;
    end
  end

  // block scale B - C while N - C rides along
  logic                 vs_v;
  ofr_pkg::svec_t       vs_vec;
  logic [2:0][DW_I-1:0] vs_ydif;

  ofr_scale #(.IN_W(DW_I), .SIDE_W(3 * DW_I)) u_scale_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d_v_r),
    .in_vec   (d_v_vec_r),
    .in_side  (d_y_vec_r),
    .out_valid(vs_v),
    .out_vec  (vs_vec),
    .out_side (vs_ydif)
  );

  // y axis
  logic               yu_v, yu_ok;
  logic [2:0][AW-1:0] yu_axis;
  ofr_pkg::svec_t     yu_vec;

  ofr_unit #(.IN_W(DW_I), .FRAC(AXIS_FRAC_BITS), .SIDE_W(SV_W)) u_unit_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vs_v),
    .in_vec   (vs_ydif),
    .in_side  (vs_vec),
    .out_valid(yu_v),
    .out_ok   (yu_ok),
    .out_axis (yu_axis),
    .out_side (yu_vec)
  );

  // dot product terms v_i * y_i
  logic                 t1_v_r, t1_ok_r;
  logic [2:0][PRW-1:0]  t1_prod_r;
  logic [2:0][VS_W-1:0] t1_vs_r;
  logic [2:0][AW-1:0]   t1_yu_r;
  logic [2:0][VS_W-1:0] vsg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsg[i] = yu_vec.neg[i] ? (VS_W'(0) - VS_W'(yu_vec.mag[i])) : VS_W'(yu_vec.mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1_prod_r[i] <= PRW'($signed(vsg[i])) * PRW'($signed(yu_axis[i]));
      end
      t1_vs_r <= vsg;
      t1_yu_r <= yu_axis;
      t1_ok_r <= yu_ok & yu_vec.nz;
    end
  end

  // dot product sum
  logic                 t2_v_r, t2_ok_r;
  logic [DW-1:0]        t2_dot_r;
  logic [2:0][VS_W-1:0] t2_vs_r;
  logic [2:0][AW-1:0]   t2_yu_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_dot_r <= DW'($signed(t1_prod_r[0])) + DW'($signed(t1_prod_r[1]))
                + DW'($signed(t1_prod_r[2]));
      t2_vs_r  <= t1_vs_r;
      t2_yu_r  <= t1_yu_r;
      t2_ok_r  <= t1_ok_r;
    end
  end

  // projection length, rounded half away from zero
  logic                 t3_v_r, t3_ok_r;
  logic [P_W-1:0]       t3_p_r;
  logic [2:0][VS_W-1:0] t3_vs_r;
  logic [2:0][AW-1:0]   t3_yu_r;
  logic [DW-1:0]        dabs, drnd;
  logic [P_W-1:0]       p_nxt;

  always_comb begin
    dabs  = t2_dot_r[DW-1] ? (~t2_dot_r + DW'(1)) : t2_dot_r;
    drnd  = (dabs + HALF) >> AXIS_FRAC_BITS;
    p_nxt = t2_dot_r[DW-1] ? (P_W'(0) - P_W'(drnd)) : P_W'(drnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_p_r  <= p_nxt;
      t3_vs_r <= t2_vs_r;
      t3_yu_r <= t2_yu_r;
      t3_ok_r <= t2_ok_r;
    end
  end

  // projection terms p * y_i
  logic                 t4_v_r, t4_ok_r;
  logic [2:0][DW-1:0]   t4_pp_r;
  logic [2:0][VS_W-1:0] t4_vs_r;
  logic [2:0][AW-1:0]   t4_yu_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t4_pp_r[i] <= DW'($signed(t3_p_r)) * DW'($signed(t3_yu_r[i]));
      end
      t4_vs_r <= t3_vs_r;
      t4_yu_r <= t3_yu_r;
      t4_ok_r <= t3_ok_r;
    end
  end

  // w = v minus rounded projection
  logic                t5_v_r, t5_ok_r;
  logic [2:0][W_W-1:0] t5_w_r;
  logic [2:0][AW-1:0]  t5_yu_r;
  logic [2:0][W_W-1:0] w_nxt;

  always_comb begin
    logic [DW-1:0] pabs, prnd;
    logic [W_W-1:0] pr;
    for (int i = 0; i < 3; i++) begin
      pabs = t4_pp_r[i][DW-1] ? (~t4_pp_r[i] + DW'(1)) : t4_pp_r[i];
      prnd = (pabs + HALF) >> AXIS_FRAC_BITS;
      pr   = t4_pp_r[i][DW-1] ? (W_W'(0) - W_W'(prnd)) : W_W'(prnd);
      w_nxt[i] = W_W'($signed(t4_vs_r[i])) - pr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_w_r  <= w_nxt;
      t5_yu_r <= t4_yu_r;
      t5_ok_r <= t4_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
      t5_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= yu_v;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
      t5_v_r <= t4_v_r;
    end
  end

  // x axis
  logic               xu_v, xu_ok;
  logic [2:0][AW-1:0] xu_axis;
  logic [YS_W-1:0]    xu_side;
  logic [2:0][AW-1:0] xs_yu;

  ofr_unit #(.IN_W(W_W), .FRAC(AXIS_FRAC_BITS), .SIDE_W(YS_W)) u_unit_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (t5_v_r),
    .in_vec   (t5_w_r),
    .in_side  ({t5_ok_r, t5_yu_r}),
    .out_valid(xu_v),
    .out_ok   (xu_ok),
    .out_axis (xu_axis),
    .out_side (xu_side)
  );

  assign xs_yu = xu_side[YS_W-2:0];

  // cross product terms
  logic                c1_v_r, c1_ok_r;
  logic [5:0][CPW-1:0] c1_cp_r;
  logic [2:0][AW-1:0]  c1_xu_r, c1_yu_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_cp_r[0] <= CPW'($signed(xu_axis[1])) * CPW'($signed(xs_yu[2]));
      c1_cp_r[1] <= CPW'($signed(xu_axis[2])) * CPW'($signed(xs_yu[1]));
      c1_cp_r[2] <= CPW'($signed(xu_axis[2])) * CPW'($signed(xs_yu[0]));
      c1_cp_r[3] <= CPW'($signed(xu_axis[0])) * CPW'($signed(xs_yu[2]));
      c1_cp_r[4] <= CPW'($signed(xu_axis[0])) * CPW'($signed(xs_yu[1]));
      c1_cp_r[5] <= CPW'($signed(xu_axis[1])) * CPW'($signed(xs_yu[0]));
      c1_xu_r    <= xu_axis;
      c1_yu_r    <= xs_yu;
      c1_ok_r    <= xu_side[YS_W-1] & xu_ok;
    end
  end

  // cross product differences
  logic               c2_v_r, c2_ok_r;
  logic [2:0][ZW-1:0] c2_z_r;
  logic [2:0][AW-1:0] c2_xu_r, c2_yu_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c2_z_r[i] <= ZW'($signed(c1_cp_r[2*i])) - ZW'($signed(c1_cp_r[2*i+1]));
      end
      c2_xu_r <= c1_xu_r;
      c2_yu_r <= c1_yu_r;
      c2_ok_r <= c1_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= xu_v;
      c2_v_r <= c1_v_r;
    end
  end

  // z axis
  logic               zu_v, zu_ok;
  logic [2:0][AW-1:0] zu_axis;
  logic [ZS_W-1:0]    zu_side;
  logic [2:0][AW-1:0] zs_xu, zs_yu;

  ofr_unit #(.IN_W(ZW), .FRAC(AXIS_FRAC_BITS), .SIDE_W(ZS_W)) u_unit_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (c2_v_r),
    .in_vec   (c2_z_r),
    .in_side  ({c2_ok_r, c2_xu_r, c2_yu_r}),
    .out_valid(zu_v),
    .out_ok   (zu_ok),
    .out_axis (zu_axis),
    .out_side (zu_side)
  );

  assign zs_xu = zu_side[6*AW-1:3*AW];
  assign zs_yu = zu_side[3*AW-1:0];

  // final word, axis fields keep their low bits
  logic            fin_valid, fin_ok;
  logic [OD_W-1:0] fin_data;

  assign fin_valid = zu_v;
  assign fin_ok    = zu_side[ZS_W-1] & zu_ok;

  always_comb begin
    fin_data = '0;
    if (fin_ok) begin
      for (int i = 0; i < 3; i++) begin
        fin_data[i*AXO_W +: AXO_W]     = AXO_W'($signed(zs_xu[i]));
        fin_data[(i+3)*AXO_W +: AXO_W] = AXO_W'($signed(zs_yu[i]));
        fin_data[(i+6)*AXO_W +: AXO_W] = AXO_W'($signed(zu_axis[i]));
      end
    end
  end

  // output register with one skid word
  logic            out_tvalid_r;
  logic [OD_W-1:0] out_data_r, skid_data_r;
  logic            out_deg_r, skid_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      skid_full_r  <= 1'b0;
    end else if (!out_tvalid_r || out_tready) begin
      if (skid_full_r) begin
        out_tvalid_r <= 1'b1;
        skid_full_r  <= 1'b0;
      end else begin
        out_tvalid_r <= fin_valid;
      end
    end else if (fin_valid && en) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_tvalid_r || out_tready) begin
      if (skid_full_r) begin
        out_data_r <= skid_data_r;
        out_deg_r  <= skid_deg_r;
      end else begin
        out_data_r <= fin_data;
        out_deg_r  <= !fin_ok;
      end
    end else if (en) begin
      skid_data_r <= fin_data;
      skid_deg_r  <= !fin_ok;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_deg_r;

  `OFR_ASSERT_IMP(a_skid_needs_out, skid_full_r, out_tvalid_r)
  `OFR_ASSERT_IMP(a_deg_is_zero, out_tvalid_r && out_tuser[0], out_tdata == '0)
  `OFR_ASSERT_NXT(a_skid_fill, out_tvalid_r && !out_tready && !skid_full_r && fin_valid, skid_full_r)
  `OFR_ASSERT_NXT(a_skid_drain, skid_full_r && out_tready, out_tvalid_r && !skid_full_r)

endmodule

/* hw/rtl/ofr_scale.sv */
module ofr_scale #(
  parameter int IN_W   = 21,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][IN_W-1:0]  in_vec,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output ofr_pkg::svec_t        out_vec,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int SW     = ofr_pkg::SCALE_W;
  localparam int POS_W  = $clog2(IN_W);
  localparam int SH_W   = $clog2(IN_W + 1);

  logic                  a_v_r, b_v_r, c_v_r;
  logic [2:0][IN_W-1:0]  a_mag_r, b_mag_r;
  logic [2:0]            a_neg_r, b_neg_r, c_neg_r;
  logic [SIDE_W-1:0]     a_side_r, b_side_r, c_side_r;
  logic [POS_W-1:0]      b_pos_r;
  logic                  b_nz_r, c_nz_r;
  logic [2:0][SW-1:0]    c_mag_r;

  logic [2:0][IN_W-1:0]  mag_nxt;
  logic [2:0]            neg_nxt;
  logic [IN_W-1:0]       orv;
  logic [POS_W-1:0]      pos_nxt;
  logic [SH_W-1:0]       shamt;
  logic [2:0][SW-1:0]    smag_nxt;

  // magnitudes and signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = in_vec[i][IN_W-1];
      mag_nxt[i] = neg_nxt[i] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    orv     = a_mag_r[0] | a_mag_r[1] | a_mag_r[2];
    pos_nxt = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (orv[i]) pos_nxt = POS_W'(i);
    end
  end

  // shift so the leading one lands on the top scaled bit
  always_comb begin
    shamt = SH_W'(b_pos_r) + SH_W'(1);
    for (int i = 0; i < 3; i++) begin
      smag_nxt[i] = SW'({b_mag_r[i], SW'(0)} >> shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= mag_nxt;
      a_neg_r  <= neg_nxt;
      a_side_r <= in_side;
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_side_r <= a_side_r;
      b_pos_r  <= pos_nxt;
      b_nz_r   <= |orv;
      c_mag_r  <= smag_nxt;
      c_neg_r  <= b_neg_r;
      c_nz_r   <= b_nz_r;
      c_side_r <= b_side_r;
    end
  end

  assign out_valid   = c_v_r;
  assign out_vec.nz  = c_nz_r;
  assign out_vec.neg = c_neg_r;
  assign out_vec.mag = c_mag_r;
  assign out_side    = c_side_r;

endmodule

/* hw/rtl/ofr_unit.sv */
module ofr_unit #(
  parameter int IN_W   = 21,
  parameter int FRAC   = 14,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][IN_W-1:0]  in_vec,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic                  out_ok,
  output logic [2:0][FRAC+1:0]  out_axis,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int SW    = ofr_pkg::SCALE_W;
  localparam int SQW   = 2 * SW;
  localparam int SUM_W = 2 * SW + 2;
  localparam int RW    = 2 * SW + 3;
  localparam int SQN   = SW + 1;
  localparam int QW    = FRAC + 1;
  localparam int DVN   = QW;
  localparam int CR_W  = SIDE_W + 4;
  localparam int AW    = FRAC + 2;
  localparam logic [QW-1:0] LIM = QW'(1) << FRAC;

  logic               sc_v;
  ofr_pkg::svec_t     sc_vec;
  logic [SIDE_W-1:0]  sc_side;

  ofr_scale #(.IN_W(IN_W), .SIDE_W(SIDE_W)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_vec   (in_vec),
    .in_side  (in_side),
    .out_valid(sc_v),
    .out_vec  (sc_vec),
    .out_side (sc_side)
  );

  // squares of the scaled magnitudes
  logic                sq_v_r;
  logic [2:0][SQW-1:0] sq_r;
  logic [2:0][SW-1:0]  sq_mag_r;
  logic [CR_W-1:0]     sq_cr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQW'(sc_vec.mag[i]) * SQW'(sc_vec.mag[i]);
      end
      sq_mag_r <= sc_vec.mag;
      sq_cr_r  <= {sc_vec.nz, sc_vec.neg, sc_side};
    end
  end

  // sum of squares
  logic               sm_v_r;
  logic [SUM_W-1:0]   sm_r;
  logic [2:0][SW-1:0] sm_mag_r;
  logic [CR_W-1:0]    sm_cr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else if (en) begin
      sm_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r     <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      sm_mag_r <= sq_mag_r;
      sm_cr_r  <= sq_cr_r;
    end
  end

  // square root, one result bit per stage
  logic               rt_v_r   [SQN];
  logic [RW-1:0]      rt_n_r   [SQN];
  logic [RW-1:0]      rt_res_r [SQN];
  logic [2:0][SW-1:0] rt_mag_r [SQN];
  logic [CR_W-1:0]    rt_cr_r  [SQN];

  for (genvar k = 0; k < SQN; k++) begin : g_rt
    localparam logic [RW-1:0] RT_BIT = RW'(1) << (2 * (SQN - 1 - k));
    logic               v_in;
    logic [RW-1:0]      n_in, res_in, trial;
    logic [2:0][SW-1:0] mag_in;
    logic [CR_W-1:0]    cr_in;

    if (k == 0) begin : g_src
      assign v_in   = sm_v_r;
      assign n_in   = RW'(sm_r);
      assign res_in = '0;
      assign mag_in = sm_mag_r;
      assign cr_in  = sm_cr_r;
    end else begin : g_src
      assign v_in   = rt_v_r[k-1];
      assign n_in   = rt_n_r[k-1];
      assign res_in = rt_res_r[k-1];
      assign mag_in = rt_mag_r[k-1];
      assign cr_in  = rt_cr_r[k-1];
    end

    assign trial = res_in + RT_BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k] <= 1'b0;
      end else if (en) begin
        rt_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= trial) begin
          rt_n_r[k]   <= n_in - trial;
          rt_res_r[k] <= (res_in >> 1) + RT_BIT;
        end else begin
          rt_n_r[k]   <= n_in;
          rt_res_r[k] <= res_in >> 1;
        end
        rt_mag_r[k] <= mag_in;
        rt_cr_r[k]  <= cr_in;
      end
    end
  end

  // rounded division by the norm, one quotient bit per stage
  logic               dv_v_r   [DVN];
  logic [2:0][RW-1:0] dv_rem_r [DVN];
  logic [2:0][QW-1:0] dv_q_r   [DVN];
  logic [SW+1:0]      dv_d_r   [DVN];
  logic [CR_W-1:0]    dv_cr_r  [DVN];

  for (genvar j = 0; j < DVN; j++) begin : g_dv
    localparam int DV_SH = QW - 1 - j;
    logic               v_in;
    logic [2:0][RW-1:0] rem_in;
    logic [2:0][QW-1:0] q_in;
    logic [SW+1:0]      d_in;
    logic [CR_W-1:0]    cr_in;
    logic [RW-1:0]      sd;

    if (j == 0) begin : g_src
      logic [SW:0] norm;
      assign norm  = rt_res_r[SQN-1][SW:0];
      assign v_in  = rt_v_r[SQN-1];
      assign d_in  = {norm, 1'b0};
      assign cr_in = rt_cr_r[SQN-1];
      assign q_in  = '0;
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign rem_in[i] = RW'({rt_mag_r[SQN-1][i], QW'(0)}) + RW'(norm);
      end
    end else begin : g_src
      assign v_in   = dv_v_r[j-1];
      assign d_in   = dv_d_r[j-1];
      assign cr_in  = dv_cr_r[j-1];
      assign q_in   = dv_q_r[j-1];
      assign rem_in = dv_rem_r[j-1];
    end

    assign sd = RW'(d_in) << DV_SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= sd) begin
            dv_rem_r[j][i] <= rem_in[i] - sd;
            dv_q_r[j][i]   <= {q_in[i][QW-2:0], 1'b1};
          end else begin
            dv_rem_r[j][i] <= rem_in[i];
            dv_q_r[j][i]   <= {q_in[i][QW-2:0], 1'b0};
          end
        end
        dv_d_r[j]  <= d_in;
        dv_cr_r[j] <= cr_in;
      end
    end
  end

  // clamp and sign
  logic                out_v_r, out_ok_r;
  logic [2:0][AW-1:0]  out_axis_r;
  logic [SIDE_W-1:0]   out_side_r;
  logic [2:0][AW-1:0]  axis_nxt;
  logic [CR_W-1:0]     cr_end;

  assign cr_end = dv_cr_r[DVN-1];

  always_comb begin
    logic [QW-1:0] qc;
    for (int i = 0; i < 3; i++) begin
      qc = (dv_q_r[DVN-1][i] > LIM) ? LIM : dv_q_r[DVN-1][i];
      axis_nxt[i] = cr_end[SIDE_W+i] ? (AW'(0) - AW'(qc)) : AW'(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[DVN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_axis_r <= axis_nxt;
      out_ok_r   <= cr_end[CR_W-1];
      out_side_r <= cr_end[SIDE_W-1:0];
    end
  end

  assign out_valid = out_v_r;
  assign out_ok    = out_ok_r;
  assign out_axis  = out_axis_r;
  assign out_side  = out_side_r;

endmodule

/* bench/orthonormal_frame_from_three_points_top_tb.sv */
module orthonormal_frame_from_three_points_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 20;
  localparam int FB = 14;
  localparam int IN_W = ((9*CW+7)/8)*8;
  localparam int LATENCY = 3*FB + 126;
  localparam int N_RANDOM = 530;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [CW-1:0] CMAX = 524287;
  localparam logic signed [CW-1:0] CMIN = -524288;

  typedef struct packed {
    logic [8:0][15:0] axis;
    logic             degen;
  } frame_t;

  typedef struct {
    logic signed [CW-1:0] pt[9];
    logic                 has_exp;
    frame_t               exp;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_W-1:0] in_tdata;
  logic [143:0] out_tdata;
  logic [0:0] out_tuser;

  frame_t frames_due[$];
  int     failures;
  int     cycles;
  int     stall_left;
  logic   sink_calm;
  string  axis_name[9] = '{"xaxis_x", "xaxis_y", "xaxis_z", "yaxis_x", "yaxis_y",
                           "yaxis_z", "zaxis_x", "zaxis_y", "zaxis_z"};

  orthonormal_frame_from_three_points_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // round half away from zero after a right shift
  function automatic longint rnd_shift(longint x, int s);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (64'sd1 <<< (s-1))) >>> s;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // shift magnitudes so the largest lands in [2^29, 2^30)
  function automatic bit scale_vec(ref longint v[3]);
    longint unsigned mg[3], m;
    int lft, rgt;
    m = 0; lft = 0; rgt = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) return 1'b0;
    while (m < (64'd1 << 29)) begin m <<= 1; lft++; end
    while (m >= (64'd1 << 30)) begin m >>= 1; rgt++; end
    for (int i = 0; i < 3; i++) begin
      mg[i] = lft ? (mg[i] << lft) : (mg[i] >> rgt);
      v[i] = (v[i] < 0) ? -longint'(mg[i]) : longint'(mg[i]);
    end
    return 1'b1;
  endfunction

  function automatic bit unit_vec(longint vin[3], ref longint u[3]);
    longint v[3];
    longint unsigned sum, nrm, num, q, mg;
    v = vin;
    if (!scale_vec(v)) return 1'b0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (v[i] < 0) ? -v[i] : v[i];
      sum += mg * mg;
    end
    nrm = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      mg = (v[i] < 0) ? -v[i] : v[i];
      num = mg << FB;
      q = (2*num + nrm) / (2*nrm);
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // gram-schmidt frame predictor
  function automatic frame_t predict_frame(logic signed [CW-1:0] pt[9]);
    frame_t f;
    longint yr[3], v[3], w[3], zr[3], xu[3], yu[3], zu[3], d, p;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      v[i]  = longint'(pt[3+i]) - longint'(pt[i]);
      yr[i] = longint'(pt[6+i]) - longint'(pt[i]);
    end
    ok = unit_vec(yr, yu);
    if (ok) ok = scale_vec(v);
    if (ok) begin
      d = v[0]*yu[0] + v[1]*yu[1] + v[2]*yu[2];
      p = rnd_shift(d, FB);
      for (int i = 0; i < 3; i++) w[i] = v[i] - rnd_shift(p*yu[i], FB);
      ok = unit_vec(w, xu);
    end
    if (ok) begin
      zr[0] = xu[1]*yu[2] - xu[2]*yu[1];
      zr[1] = xu[2]*yu[0] - xu[0]*yu[2];
      zr[2] = xu[0]*yu[1] - xu[1]*yu[0];
      ok = unit_vec(zr, zu);
    end
    f = '0;
    f.degen = !ok;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        f.axis[i]   = xu[i][15:0];
        f.axis[3+i] = yu[i][15:0];
        f.axis[6+i] = zu[i][15:0];
      end
    end
    return f;
  endfunction

  function automatic row_t mk_row(int c0, int c1, int c2, int s0, int s1, int s2,
                                  int r0, int r1, int r2);
    row_t r;
    r.pt[0] = CW'(c0); r.pt[1] = CW'(c1); r.pt[2] = CW'(c2);
    r.pt[3] = CW'(s0); r.pt[4] = CW'(s1); r.pt[5] = CW'(s2);
    r.pt[6] = CW'(r0); r.pt[7] = CW'(r1); r.pt[8] = CW'(r2);
    r.has_exp = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  function automatic row_t mk_axes(row_t r, int x0, int x1, int x2, int y0, int y1,
                                   int y2, int z0, int z1, int z2, bit dg);
    int a[9];
    a = '{x0, x1, x2, y0, y1, y2, z0, z1, z2};
    r.has_exp = 1'b1;
    for (int i = 0; i < 9; i++) r.exp.axis[i] = a[i][15:0];
    r.exp.degen = dg;
    return r;
  endfunction

  task automatic send_word(row_t r);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CW +: CW] = r.pt[i];
    frames_due.push_back(r.has_exp ? r.exp : predict_frame(r.pt));
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_burst();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return CW'(int'($urandom_range(0, 255)) - 128);
      default: return CW'($urandom());
    endcase
  endfunction

  // output side: compare each frame word with the oldest expectation
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frames_due.size() == 0) begin
        $error("frame word with no expectation waiting");
        failures++;
      end else begin
        want = frames_due.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_tdata[i*16 +: 16] !== want.axis[i]) begin
            $error("%s: expected %0d actual %0d", axis_name[i],
                   $signed(want.axis[i]), $signed(out_tdata[i*16 +: 16]));
            failures++;
          end
        if (out_tuser[0] !== want.degen) begin
          $error("degenerate: expected %0d actual %0d", want.degen, out_tuser[0]);
          failures++;
        end
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n || sink_calm) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= int'($urandom_range(0, 9));
    end else begin
      out_tready <= 1'b1;
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int k;
    failures = 0;
    cycles = 0;
    sink_calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: axis-aligned frames, degenerate cases, extremes
    rows.push_back(mk_axes(mk_row(0,0,0, 256,0,0, 0,256,0),
                   16384,0,0, 0,16384,0, 0,0,16384, 0));
    rows.push_back(mk_axes(mk_row(0,0,0, 0,0,256, 256,0,0),
                   0,0,16384, 16384,0,0, 0,16384,0, 0));
    rows.push_back(mk_axes(mk_row(5,5,5, 9,9,9, 5,5,5), 0,0,0, 0,0,0, 0,0,0, 1));
    rows.push_back(mk_axes(mk_row(7,-3,2, 7,-3,2, 100,0,0), 0,0,0, 0,0,0, 0,0,0, 1));
    rows.push_back(mk_axes(mk_row(0,0,0, 512,0,0, 256,0,0), 0,0,0, 0,0,0, 0,0,0, 1));
    rows.push_back(mk_axes(mk_row(CMIN,CMIN,CMIN, CMIN,CMIN,CMIN, CMIN,CMIN,CMIN),
                   0,0,0, 0,0,0, 0,0,0, 1));
    rows.push_back(mk_row(CMIN,CMIN,CMIN, CMAX,CMIN,CMIN, CMIN,CMAX,CMIN));
    rows.push_back(mk_row(CMAX,CMAX,CMAX, CMIN,CMAX,CMAX, CMAX,CMIN,CMAX));
    rows.push_back(mk_row(CMAX,CMIN,CMAX, CMIN,CMAX,CMIN, CMAX,CMAX,CMIN));
    rows.push_back(mk_row(0,0,0, 1,0,0, 0,1,0));
    rows.push_back(mk_row(0,0,0, 1,1,0, 0,0,1));
    rows.push_back(mk_row(0,0,0, 1000,1,0, 2000,0,0));
    rows.push_back(mk_row(0,0,0, -1,-1,-1, 1,1,1));
    rows.push_back(mk_row(-100,200,-300, 400,-500,600, -700,800,-900));
    rows.push_back(mk_row(0,0,0, 300000,1,2, -300000,0,0));
    rows.push_back(mk_row(12,34,56, 13,34,56, 12,35,57));
    foreach (rows[i]) begin
      send_word(rows[i]);
      if ($urandom_range(0, 3) == 0) idle_burst();
    end
    in_tvalid <= 1'b0;

    // hold off until every expected frame is out
    while (frames_due.size() != 0) @(posedge clk);

    // random part, last stretch without idling
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 80) sink_calm <= 1'b1;
      for (int i = 0; i < 9; i++) r.pt[i] = rnd_coord();
      k = $urandom_range(0, 9);
      if (k == 0) for (int i = 0; i < 3; i++) r.pt[6+i] = r.pt[i];
      if (k == 1) for (int i = 0; i < 3; i++) r.pt[3+i] = r.pt[i];
      if (k == 2)
        for (int i = 0; i < 3; i++)
          r.pt[3+i] = CW'(r.pt[i] + 2*(r.pt[6+i] - r.pt[i]));
      if (k == 3)
        for (int i = 0; i < 9; i++) r.pt[i] = CW'(int'($urandom_range(0, 63)) - 32);
      r.has_exp = 1'b0;
      send_word(r);
      if (n < N_RANDOM - 80 && $urandom_range(0, 4) == 0) idle_burst();
    end
    in_tvalid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* orthonormal_frame_from_three_points_top.f */
+incdir+hw/rtl
hw/rtl/ofr_pkg.sv
hw/rtl/ofr_scale.sv
hw/rtl/ofr_unit.sv
hw/rtl/orthonormal_frame_from_three_points_top.sv
bench/orthonormal_frame_from_three_points_top_tb.sv
